### sv/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the step pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spg_pkg;

    localparam int NUM_CORRECTORS = 3;
    localparam int CMP_W          = 16;
    localparam int COUNT_W        = 24;
    localparam int OVF_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int CORR_IDX_W     = $clog2(NUM_CORRECTORS + 1);
    localparam int EXTRA_W        = $clog2(NUM_CORRECTORS + 1);
    localparam int STEP_CNT_W     = $clog2(COUNT_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_TICKS  = 3'd0,
        CFG_PAUSE_TICKS  = 3'd1,
        CFG_STEP_LIMIT   = 3'd2,
        CFG_OVF_RELOAD   = 3'd3,
        CFG_CORRECTOR_A  = 3'd4,
        CFG_CORRECTOR_B  = 3'd5,
        CFG_CORRECTOR_C  = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CSEL  = 5'b00010,
        S_CWAIT = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic done;
        logic divides;
    } t_mod_status;

endpackage

### sv/spg_mod_unit.sv
// ----------------------------------------------------------------------------
// spg_mod_unit
// Bit-serial remainder unit: tests whether a divisor divides the step count,
// one restoring step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spg_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spg_pkg::COUNT_W-1:0] i_dividend,
    input  logic [spg_pkg::CMP_W-1:0]   i_divisor,
    output spg_pkg::t_mod_status        o_status
);
    import spg_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0]    r_dvd;
    logic [CMP_W-1:0]      r_div;
    logic [CMP_W-1:0]      r_rem;
    logic [CMP_W:0]        shifted;
    logic [CMP_W-1:0]      n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[COUNT_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = CMP_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[CMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(COUNT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[COUNT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_status.done    = r_done;
    assign o_status.divides = (r_rem == '0);

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("remainder unit done held for two cycles");

endmodule

### sv/stepper_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_pulse_generator
// Step pulse generator for one stepper channel, driven by compare events.
// ----------------------------------------------------------------------------
// usage: a request with i_mode 1 restarts a move at i_start_compare; each
// request with i_mode 0 is one compare match of the timer. every request
// returns one result: step level, next compare value, step count and the
// overflow wait, finished and ignored flags.
// the configuration port takes a write whenever i_cfg_we is high; write it
// only while no request is in flight.
// restart, overflow wait, pulse start and ignored events pass from the idle
// state to the output state, which loads the result. a pulse end runs the
// corrector check on the shared bit-serial remainder unit, once for each
// nonzero divisor, then goes through the finish state to the output state.
// one request is worked on at a time; o_ready is low from acceptance until
// the result is moved into the output register, so a new request is only
// taken once the result of the last one has been moved there.
// the output register holds a result while i_ready is low; the next request
// can be taken meanwhile but its result waits until the register frees.
// reset: synchronous and active low, loads the register defaults, disarms
// the block and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_pulse_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [spg_pkg::CMP_W-1:0]      i_start_compare,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_step_level,
    output logic [spg_pkg::CMP_W-1:0]      o_compare_value,
    output logic [spg_pkg::COUNT_W-1:0]    o_step_count,
    output logic                           o_overflow_wait,
    output logic                           o_finished,
    output logic                           o_ignored
);
    import spg_pkg::*;

    // configuration
    logic [CMP_W-1:0]   r_pulse_ticks;
    logic [CMP_W-1:0]   r_pause_ticks;
    logic [COUNT_W-1:0] r_step_limit;
    logic [OVF_W-1:0]   r_ovf_reload;
    logic [CMP_W-1:0]   r_corr_a;
    logic [CMP_W-1:0]   r_corr_b;
    logic [CMP_W-1:0]   r_corr_c;

    // channel state
    t_state             r_state, n_state;
    logic               r_high, n_high;
    logic [CMP_W-1:0]   r_compare, n_compare;
    logic [COUNT_W-1:0] r_pulses, n_pulses;
    logic [OVF_W-1:0]   r_ovf_left, n_ovf_left;
    logic               r_armed, n_armed;
    logic               r_flag_wait, n_flag_wait;
    logic               r_flag_fin, n_flag_fin;
    logic               r_flag_ign, n_flag_ign;
    logic [EXTRA_W-1:0] r_extra, n_extra;
    logic [CORR_IDX_W-1:0] r_corr_idx, n_corr_idx;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_level;
    logic [CMP_W-1:0]   r_out_compare;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_wait;
    logic               r_out_fin;
    logic               r_out_ign;
    logic               out_load;

    logic [CMP_W-1:0]   sel_div;
    logic               corr_active;
    logic               mod_start;
    t_mod_status        mod_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= CMP_W'(100);
            r_pause_ticks <= CMP_W'(1000);
            r_step_limit  <= '0;
            r_ovf_reload  <= '0;
            r_corr_a      <= '0;
            r_corr_b      <= '0;
            r_corr_c      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PULSE_TICKS: r_pulse_ticks <= i_cfg_data[CMP_W-1:0];
                CFG_PAUSE_TICKS: r_pause_ticks <= i_cfg_data[CMP_W-1:0];
                CFG_STEP_LIMIT:  r_step_limit  <= i_cfg_data[COUNT_W-1:0];
                CFG_OVF_RELOAD:  r_ovf_reload  <= i_cfg_data[OVF_W-1:0];
                CFG_CORRECTOR_A: r_corr_a      <= i_cfg_data[CMP_W-1:0];
                CFG_CORRECTOR_B: r_corr_b      <= i_cfg_data[CMP_W-1:0];
                CFG_CORRECTOR_C: r_corr_c      <= i_cfg_data[CMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // corrector divisor for the current slot
    always_comb begin
        case (r_corr_idx)
            CORR_IDX_W'(0): sel_div = r_corr_a;
            CORR_IDX_W'(1): sel_div = r_corr_b;
            CORR_IDX_W'(2): sel_div = r_corr_c;
            default:        sel_div = '0;
        endcase
    end

    assign corr_active = (r_corr_idx < CORR_IDX_W'(NUM_CORRECTORS));
    assign mod_start   = (r_state == S_CSEL) && corr_active && (sel_div != '0);
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign o_ready     = (r_state == S_IDLE);

    spg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_pulses),
        .i_divisor  (sel_div),
        .o_status   (mod_status)
    );

    always_comb begin
        n_state     = r_state;
        n_high      = r_high;
        n_compare   = r_compare;
        n_pulses    = r_pulses;
        n_ovf_left  = r_ovf_left;
        n_armed     = r_armed;
        n_flag_wait = r_flag_wait;
        n_flag_fin  = r_flag_fin;
        n_flag_ign  = r_flag_ign;
        n_extra     = r_extra;
        n_corr_idx  = r_corr_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_flag_wait = 1'b0;
                    n_flag_fin  = 1'b0;
                    n_flag_ign  = 1'b0;
                    n_state     = S_OUT;
                    if (i_mode) begin
                        n_compare  = i_start_compare;
                        n_ovf_left = r_ovf_reload;
                        n_pulses   = '0;
                        n_high     = 1'b0;
                        n_armed    = 1'b1;
                    end else if (!r_armed) begin
                        n_flag_ign = 1'b1;
                    end else if (r_high) begin
                        n_extra    = '0;
                        n_corr_idx = '0;
                        n_state    = S_CSEL;
                    end else if (r_ovf_left != '0) begin
                        n_ovf_left  = r_ovf_left - 1'b1;
                        n_flag_wait = 1'b1;
                    end else begin
                        n_high     = 1'b1;
                        n_compare  = r_compare + r_pulse_ticks;
                        n_pulses   = r_pulses + 1'b1;
                        n_ovf_left = r_ovf_reload;
                    end
                end
            end
            S_CSEL: begin
                if (!corr_active) begin
                    n_state = S_FIN;
                end else if (sel_div == '0) begin
                    n_corr_idx = r_corr_idx + 1'b1;
                end else begin
                    n_state = S_CWAIT;
                end
            end
            S_CWAIT: begin
                if (mod_status.done) begin
                    if (mod_status.divides) begin
                        n_extra = r_extra + 1'b1;
                    end
                    n_corr_idx = r_corr_idx + 1'b1;
                    n_state    = S_CSEL;
                end
            end
            S_FIN: begin
                n_high    = 1'b0;
                n_compare = r_compare + r_pause_ticks + CMP_W'(r_extra);
                if (r_pulses >= r_step_limit) begin
                    n_armed    = 1'b0;
                    n_flag_fin = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_high      <= 1'b0;
            r_compare   <= '0;
            r_pulses    <= '0;
            r_ovf_left  <= '0;
            r_armed     <= 1'b0;
            r_flag_wait <= 1'b0;
            r_flag_fin  <= 1'b0;
            r_flag_ign  <= 1'b0;
            r_extra     <= '0;
            r_corr_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_high      <= n_high;
            r_compare   <= n_compare;
            r_pulses    <= n_pulses;
            r_ovf_left  <= n_ovf_left;
            r_armed     <= n_armed;
            r_flag_wait <= n_flag_wait;
            r_flag_fin  <= n_flag_fin;
            r_flag_ign  <= n_flag_ign;
            r_extra     <= n_extra;
            r_corr_idx  <= n_corr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_level   <= r_high;
            r_out_compare <= r_compare;
            r_out_count   <= r_pulses;
            r_out_wait    <= r_flag_wait;
            r_out_fin     <= r_flag_fin;
            r_out_ign     <= r_flag_ign;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_step_level    = r_out_level;
    assign o_compare_value = r_out_compare;
    assign o_step_count    = r_out_count;
    assign o_overflow_wait = r_out_wait;
    assign o_finished      = r_out_fin;
    assign o_ignored       = r_out_ign;

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_overflow_wait, o_finished, o_ignored}) <= 1))
        else $error("more than one result flag set");

    a_ignored_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ignored) |-> !o_step_level)
        else $error("ignored event reported with step output high");

    a_finished_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> !o_step_level)
        else $error("finished reported with step output high");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while the previous one is in flight");

    a_disarmed_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> !r_high)
        else $error("step output high while disarmed");

endmodule
